[sv/pgps_pkg.sv]
// Package for the point-source gravity particle stepper.
// Holds field widths, reset values, register codes, sequencer states and
// saturation helpers. No dependencies.
package pgps_pkg;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 32;
  localparam int TIME_W = 24;
  localparam int CFG_W  = 32;

  localparam int PARTICLES_DEF = 1024;

  localparam logic signed [POS_W-1:0] SOURCE_X_RST = 32'sd0;
  localparam logic signed [POS_W-1:0] SOURCE_Y_RST = 32'sd0;
  localparam logic signed [POS_W-1:0] GRAVITY_RST  = -32'sd2294;
  localparam logic signed [POS_W-1:0] VEL_X_RST    = 32'sd1966;
  localparam logic signed [POS_W-1:0] VEL_Y_RST    = 32'sd0;

  // Serial unit step counts (last step index).
  localparam logic [5:0] MUL_LAST  = 6'd32;
  localparam logic [5:0] DIV_LAST  = 6'd32;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  typedef enum logic [1:0] {
    REG_SOURCE_X = 2'd0,
    REG_SOURCE_Y = 2'd1,
    REG_GRAVITY  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_READ,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_LEN2,
    S_DIVN,
    S_MULA,
    S_DIVA,
    S_AMAG,
    S_MULT,
    S_WRITE,
    S_POS
  } state_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_0000_7FFF_FFFF;
    lo = -50'sh0_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

endpackage

[sv/pgps_if.sv]
// Handshake channels for the gravity particle stepper: one particle channel
// and one result channel. Depends on pgps_pkg for field widths.
interface pgps_particle_if;
  logic                                valid;
  logic                                ready;
  logic [pgps_pkg::IDX_W-1:0]          particle_index;
  logic signed [pgps_pkg::POS_W-1:0]   pos_x;
  logic signed [pgps_pkg::POS_W-1:0]   pos_y;
  logic [pgps_pkg::TIME_W-1:0]         elapsed_ms;
  logic                                held;

  modport source(output valid, particle_index, pos_x, pos_y, elapsed_ms, held,
                 input ready);
  modport sink(input valid, particle_index, pos_x, pos_y, elapsed_ms, held,
               output ready);
endinterface

interface pgps_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgps_pkg::POS_W-1:0]   new_x;
  logic signed [pgps_pkg::POS_W-1:0]   new_y;
  logic signed [pgps_pkg::POS_W-1:0]   vel_x_out;
  logic signed [pgps_pkg::POS_W-1:0]   vel_y_out;
  logic                                coincident;

  modport source(output valid, new_x, new_y, vel_x_out, vel_y_out, coincident,
                 input ready);
  modport sink(input valid, new_x, new_y, vel_x_out, vel_y_out, coincident,
               output ready);
endinterface

[sv/point_gravity_particle_step.sv]
// Top level of the point-source gravity particle stepper.
// Depends on pgps_pkg and the channel interfaces in pgps_if.sv.
//
// One Euler step of inverse-square gravity per particle, in Q16.16 fixed
// point, with a velocity entry per particle held in an on-chip memory. The
// block works on one particle at a time. After reset it writes the reset
// velocities into every memory entry and accepts no particle meanwhile;
// configuration writes are taken throughout. All arithmetic runs
// through narrow serial units that handle one bit (two for the square root)
// per cycle: a shift-add multiplier of 33 steps, a restoring divider of 33
// steps and a square root of 32 steps. For each axis whose acceleration
// magnitude reaches 2^32 or more, the second division is skipped; a particle
// sitting on the source skips the divisions and multiplications after the
// square root, and a held particle skips all arithmetic. An index at or
// above PARTICLES is reduced by PARTICLES in the wrap state until it falls
// below. The result sits in an output register, and the next particle is
// taken from the cycle after the result is loaded, while it waits for its
// transfer.
module point_gravity_particle_step #(
  parameter int PARTICLES = pgps_pkg::PARTICLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [pgps_pkg::CFG_W-1:0]    cfg_data,
  pgps_particle_if.sink                 particle,
  pgps_result_if.source                 result
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  // Configuration registers.
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic signed [31:0] gravity;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x <= pgps_pkg::SOURCE_X_RST;
      source_y <= pgps_pkg::SOURCE_Y_RST;
      gravity  <= pgps_pkg::GRAVITY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pgps_pkg::REG_SOURCE_X: source_x <= cfg_data;
        pgps_pkg::REG_SOURCE_Y: source_y <= cfg_data;
        pgps_pkg::REG_GRAVITY:  gravity  <= cfg_data;
        default: ;
      endcase
    end
  end

  pgps_pkg::state_t st, st_next;

  logic [5:0]         cnt;
  logic               ax;
  logic [AW-1:0]      clr_cnt;

  // Latched particle.
  logic [9:0]         idx;
  logic signed [31:0] px, py;
  logic [23:0]        tm;
  logic               held;

  logic signed [31:0] vx, vy;
  logic signed [31:0] dx, dy;
  logic               coin;

  // Serial multiplier.
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        mul_p;
  logic [33:0]        mul_sum;
  logic [65:0]        mul_next;

  // Square root.
  logic [63:0]        d2;
  logic [63:0]        sq_rad;
  logic [33:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [35:0]        sq_t;
  logic [35:0]        sq_trial;
  logic               sq_ge;
  logic [35:0]        sq_diff;
  logic [31:0]        root_next;

  logic [31:0]        len;
  logic [63:0]        len2;

  // Restoring divider.
  logic [32:0]        dv_num;
  logic [63:0]        dv_den;
  logic [63:0]        dv_rem;
  logic [32:0]        dv_q;
  logic [64:0]        dv_t;
  logic               dv_ge;
  logic [64:0]        dv_diff;
  logic [32:0]        q_next;

  logic               clamp;
  logic               dneg;

  // Velocity memory.
  logic signed [31:0] mem_x [PARTICLES];
  logic signed [31:0] mem_y [PARTICLES];
  logic signed [31:0] rd_x, rd_y;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_x, wr_y;
  logic [AW-1:0]      rd_addr;

  // Result staging.
  logic               out_load;

  // Combinational helpers.
  logic signed [31:0] dx_c, dy_c;
  logic signed [31:0] d_cur;
  logic [31:0]        dmag_x, dmag_y, dmag_cur;
  logic [31:0]        gmag;
  logic               a_big;
  logic [31:0]        amag;
  logic [47:0]        dvm;
  logic signed [31:0] v_cur;
  logic signed [49:0] v_sum;
  logic signed [31:0] v_new;
  logic signed [31:0] nx_c, ny_c;
  logic               idx_over;

  assign rd_addr = AW'(idx);
  assign idx_over = {22'd0, idx} >= 32'(PARTICLES);

  assign dx_c = pgps_pkg::sat32(50'(px) - 50'(source_x));
  assign dy_c = pgps_pkg::sat32(50'(py) - 50'(source_y));
  assign dmag_x = dx[31] ? 32'(-dx) : 32'(dx);
  assign dmag_y = dy[31] ? 32'(-dy) : 32'(dy);
  assign d_cur = ax ? dy : dx;
  assign dmag_cur = ax ? dmag_y : dmag_x;
  assign gmag = gravity[31] ? 32'(-gravity) : 32'(gravity);

  assign mul_sum  = {1'b0, mul_p[65:33]} + (mul_b[0] ? {1'b0, mul_a} : 34'd0);
  assign mul_next = {mul_sum, mul_p[32:1]};

  assign sq_t      = {sq_rem, sq_rad[63:62]};
  assign sq_trial  = {2'b00, sq_root, 2'b01};
  assign sq_ge     = sq_t >= sq_trial;
  assign sq_diff   = sq_t - sq_trial;
  assign root_next = {sq_root[30:0], sq_ge};

  assign dv_t    = {dv_rem, dv_num[32]};
  assign dv_ge   = dv_t >= {1'b0, dv_den};
  assign dv_diff = dv_t - {1'b0, dv_den};
  assign q_next  = {dv_q[31:0], dv_ge};

  // An acceleration at or beyond 2^31 saturates: to 2^31 when negative, and
  // to 2^31 - 1 when positive.
  assign a_big = clamp || dv_q[32] || dv_q[31];
  assign amag  = a_big ? (dneg ? 32'h8000_0000 : 32'h7FFF_FFFF) : dv_q[31:0];

  assign dvm   = mul_next[55:8];
  assign v_cur = ax ? vy : vx;
  assign v_sum = dneg ? (50'(v_cur) - 50'($signed({1'b0, dvm})))
                      : (50'(v_cur) + 50'($signed({1'b0, dvm})));
  assign v_new = pgps_pkg::sat32(v_sum);

  assign nx_c = held ? px : pgps_pkg::sat32(50'(px) + 50'(vx));
  assign ny_c = held ? py : pgps_pkg::sat32(50'(py) + 50'(vy));

  // Next-state logic.
  always_comb begin
    st_next = st;
    case (st)
      pgps_pkg::S_CLEAR: if (clr_cnt == AW'(PARTICLES - 1)) st_next = pgps_pkg::S_IDLE;
      pgps_pkg::S_IDLE:  if (particle.valid) st_next = pgps_pkg::S_WRAP;
      pgps_pkg::S_WRAP:  if (!idx_over) st_next = pgps_pkg::S_READ;
      pgps_pkg::S_READ:  st_next = pgps_pkg::S_DIFF;
      pgps_pkg::S_DIFF:  st_next = held ? pgps_pkg::S_POS : pgps_pkg::S_SQX;
      pgps_pkg::S_SQX:   if (cnt == pgps_pkg::MUL_LAST) st_next = pgps_pkg::S_SQY;
      pgps_pkg::S_SQY:   if (cnt == pgps_pkg::MUL_LAST) st_next = pgps_pkg::S_SQRT;
      pgps_pkg::S_SQRT: begin
        if (cnt == pgps_pkg::SQRT_LAST) begin
          st_next = (root_next == 32'd0) ? pgps_pkg::S_POS : pgps_pkg::S_LEN2;
        end
      end
      pgps_pkg::S_LEN2:  if (cnt == pgps_pkg::MUL_LAST) st_next = pgps_pkg::S_DIVN;
      pgps_pkg::S_DIVN:  if (cnt == pgps_pkg::DIV_LAST) st_next = pgps_pkg::S_MULA;
      pgps_pkg::S_MULA: begin
        if (cnt == pgps_pkg::MUL_LAST) begin
          st_next = ({32'd0, mul_next[63:32]} >= len2) ? pgps_pkg::S_AMAG
                                                      : pgps_pkg::S_DIVA;
        end
      end
      pgps_pkg::S_DIVA:  if (cnt == pgps_pkg::DIV_LAST) st_next = pgps_pkg::S_AMAG;
      pgps_pkg::S_AMAG:  st_next = pgps_pkg::S_MULT;
      pgps_pkg::S_MULT: begin
        if (cnt == pgps_pkg::MUL_LAST) begin
          st_next = ax ? pgps_pkg::S_WRITE : pgps_pkg::S_DIVN;
        end
      end
      pgps_pkg::S_WRITE: st_next = pgps_pkg::S_POS;
      pgps_pkg::S_POS:   if (out_load) st_next = pgps_pkg::S_IDLE;
      default:           st_next = pgps_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    particle.ready = 1'b0;
    mem_we         = 1'b0;
    wr_addr        = clr_cnt;
    wr_x           = pgps_pkg::VEL_X_RST;
    wr_y           = pgps_pkg::VEL_Y_RST;
    out_load       = 1'b0;
    case (st)
      pgps_pkg::S_CLEAR: mem_we = 1'b1;
      pgps_pkg::S_IDLE:  particle.ready = 1'b1;
      pgps_pkg::S_WRITE: begin
        mem_we  = 1'b1;
        wr_addr = rd_addr;
        wr_x    = vx;
        wr_y    = vy;
      end
      pgps_pkg::S_POS:   out_load = !result.valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pgps_pkg::S_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // Velocity memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (st == pgps_pkg::S_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    cnt <= cnt + 6'd1;
    case (st)
      pgps_pkg::S_IDLE: begin
        idx  <= particle.particle_index;
        px   <= particle.pos_x;
        py   <= particle.pos_y;
        tm   <= particle.elapsed_ms;
        held <= particle.held;
        coin <= 1'b0;
        ax   <= 1'b0;
      end
      pgps_pkg::S_WRAP: begin
        if (idx_over) idx <= idx - 10'(PARTICLES);
      end
      pgps_pkg::S_DIFF: begin
        vx    <= rd_x;
        vy    <= rd_y;
        dx    <= dx_c;
        dy    <= dy_c;
        mul_a <= {1'b0, dx_c[31] ? 32'(-dx_c) : 32'(dx_c)};
        mul_b <= {1'b0, dx_c[31] ? 32'(-dx_c) : 32'(dx_c)};
        mul_p <= '0;
        cnt   <= '0;
      end
      pgps_pkg::S_SQX, pgps_pkg::S_SQY, pgps_pkg::S_LEN2,
      pgps_pkg::S_MULA, pgps_pkg::S_MULT: begin
        mul_p <= mul_next;
        mul_b <= {1'b0, mul_b[32:1]};
        if (cnt == pgps_pkg::MUL_LAST) begin
          cnt <= '0;
          case (st)
            pgps_pkg::S_SQX: begin
              d2    <= mul_next[63:0];
              mul_a <= {1'b0, dmag_y};
              mul_b <= {1'b0, dmag_y};
              mul_p <= '0;
            end
            pgps_pkg::S_SQY: begin
              sq_rad  <= d2 + mul_next[63:0];
              sq_rem  <= '0;
              sq_root <= '0;
            end
            pgps_pkg::S_LEN2: begin
              len2   <= mul_next[63:0];
              dv_den <= {32'd0, len};
              dv_rem <= {33'd0, dmag_x[31:1]};
              dv_num <= {dmag_x[0], 32'd0};
              dv_q   <= '0;
              dneg   <= gravity[31] ^ dx[31];
            end
            pgps_pkg::S_MULA: begin
              clamp  <= {32'd0, mul_next[63:32]} >= len2;
              dv_den <= len2;
              dv_rem <= {33'd0, mul_next[63:33]};
              dv_num <= mul_next[32:0];
              dv_q   <= '0;
            end
            pgps_pkg::S_MULT: begin
              if (ax) begin
                vy <= v_new;
              end else begin
                vx     <= v_new;
                ax     <= 1'b1;
                dv_den <= {32'd0, len};
                dv_rem <= {33'd0, dmag_y[31:1]};
                dv_num <= {dmag_y[0], 32'd0};
                dv_q   <= '0;
                dneg   <= gravity[31] ^ dy[31];
              end
            end
            default: ;
          endcase
        end
      end
      pgps_pkg::S_SQRT: begin
        sq_rad  <= {sq_rad[61:0], 2'b00};
        sq_rem  <= sq_ge ? sq_diff[33:0] : sq_t[33:0];
        sq_root <= root_next;
        if (cnt == pgps_pkg::SQRT_LAST) begin
          len   <= root_next;
          coin  <= root_next == 32'd0;
          mul_a <= {1'b0, root_next};
          mul_b <= {1'b0, root_next};
          mul_p <= '0;
          cnt   <= '0;
        end
      end
      pgps_pkg::S_DIVN, pgps_pkg::S_DIVA: begin
        dv_rem <= dv_ge ? dv_diff[63:0] : dv_t[63:0];
        dv_num <= {dv_num[31:0], 1'b0};
        dv_q   <= q_next;
        if (cnt == pgps_pkg::DIV_LAST) begin
          cnt <= '0;
          if (st == pgps_pkg::S_DIVN) begin
            clamp <= 1'b0;
            mul_a <= {1'b0, gmag};
            mul_b <= q_next;
            mul_p <= '0;
          end
        end
      end
      pgps_pkg::S_AMAG: begin
        mul_a <= {1'b0, amag};
        mul_b <= {9'd0, tm};
        mul_p <= '0;
        cnt   <= '0;
      end
      default: ;
    endcase
    // The direction numerator uses the offset of the axis being worked on.
    if (st == pgps_pkg::S_AMAG && d_cur == 32'sd0 && dmag_cur == 32'd0) begin
      dneg <= dneg;
    end
  end

  // Output register: loaded when it is empty or its result is being transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.new_x      <= nx_c;
      result.new_y      <= ny_c;
      result.vel_x_out  <= vx;
      result.vel_y_out  <= vy;
      result.coincident <= coin;
    end
  end

endmodule

[tb/tb_point_gravity_particle_step.sv]
// Self-checking testbench for the point-source gravity particle stepper.
// Depends on pgps_pkg, pgps_if.sv and point_gravity_particle_step.sv.
`timescale 1ns / 1ps

module tb_point_gravity_particle_step;

  localparam int NPART = 1024;

  // One expected result, held until the matching transfer on the result side.
  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               coin;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = pgps_pkg::REG_SOURCE_X;
  logic [31:0] cfg_data = '0;

  pgps_particle_if particle ();
  pgps_result_if   result ();

  point_gravity_particle_step #(.PARTICLES(NPART)) i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .particle(particle.sink), .result(result.source)
  );

  always #10 clk = ~clk;

  // Predictor state: the configured source and strength, and the velocity
  // memory as the block should hold it.
  longint src_x, src_y, strength;
  longint vel_x_mem [NPART];
  longint vel_y_mem [NPART];
  step_t expected_steps[$];
  int errors = 0;
  int results_seen = 0;
  int coincident_seen = 0;
  int held_seen = 0;
  bit idle_allowed = 1'b1;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(64'd0) - v : v;
  endfunction

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Velocity change along one axis from offset d, length len and time t.
  function automatic longint axis_dv(longint d, longint unsigned len, longint unsigned t);
    longint unsigned n, a;
    longint acc, dv;
    bit neg;
    n = (abs64(d) << 32) / len;
    a = (abs64(strength) * n) / (len * len);
    neg = (strength < 0) != (d < 0);
    if (a > 64'h8000_0000) a = 64'h8000_0000;
    acc = clamp32(neg ? -longint'(a) : longint'(a));
    dv = longint'((abs64(acc) * t) >> 8);
    return (acc < 0) ? -dv : dv;
  endfunction

  function automatic step_t predict_step(logic [9:0] idx, logic signed [31:0] px,
                                         logic signed [31:0] py, logic [23:0] t,
                                         logic hold);
    step_t s;
    longint vx, vy, dx, dy, nx, ny;
    longint unsigned len;
    vx = vel_x_mem[idx % NPART];
    vy = vel_y_mem[idx % NPART];
    nx = px;
    ny = py;
    s.coin = 1'b0;
    if (!hold) begin
      dx = clamp32(longint'(px) - src_x);
      dy = clamp32(longint'(py) - src_y);
      len = root64(abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy));
      if (len == 0) begin
        s.coin = 1'b1;
      end else begin
        vx = clamp32(vx + axis_dv(dx, len, t));
        vy = clamp32(vy + axis_dv(dy, len, t));
        vel_x_mem[idx % NPART] = vx;
        vel_y_mem[idx % NPART] = vy;
      end
      nx = clamp32(longint'(px) + vx);
      ny = clamp32(longint'(py) + vy);
    end
    s.nx = nx[31:0];
    s.ny = ny[31:0];
    s.vx = vx[31:0];
    s.vy = vy[31:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
  endtask

  // Random idle burst on the particle side, unless idling has been switched off.
  task automatic maybe_idle();
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      particle.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Sends one particle and records its predicted result when it transfers.
  // Valid stays high on return; an idle burst in the next send or a drain takes it down.
  task automatic send_particle(logic [9:0] idx, logic signed [31:0] px,
                               logic signed [31:0] py, logic [23:0] t, logic hold);
    maybe_idle();
    particle.valid <= 1'b1;
    particle.particle_index <= idx;
    particle.pos_x <= px;
    particle.pos_y <= py;
    particle.elapsed_ms <= t;
    particle.held <= hold;
    @(posedge clk);
    while (!particle.ready) @(posedge clk);
    expected_steps.push_back(predict_step(idx, px, py, t, hold));
    if (hold) held_seen++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    particle.valid <= 1'b0;
    while (expected_steps.size() != 0) @(negedge clk);
    // A held or coincident particle may still be in flight in the pipeline
    // only if it was expected; with nothing expected a short pause suffices.
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(pgps_pkg::cfg_reg_t r, logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (r)
      pgps_pkg::REG_SOURCE_X: src_x = longint'(signed'(v));
      pgps_pkg::REG_SOURCE_Y: src_y = longint'(signed'(v));
      default:                strength = longint'(signed'(v));
    endcase
  endtask

  // Result side: random stalls while idling is allowed, then each transfer is checked field by field.
  initial begin
    step_t w;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_allowed && $urandom_range(0, 3) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        results_seen++;
        if (expected_steps.size() == 0) begin
          report_mismatch("unexpected result new_x", result.new_x, 32'd0);
        end else begin
          w = expected_steps.pop_front();
          if (w.coin) coincident_seen++;
          if (result.new_x !== w.nx) report_mismatch("new_x", result.new_x, w.nx);
          if (result.new_y !== w.ny) report_mismatch("new_y", result.new_y, w.ny);
          if (result.vel_x_out !== w.vx) report_mismatch("vel_x_out", result.vel_x_out, w.vx);
          if (result.vel_y_out !== w.vy) report_mismatch("vel_y_out", result.vel_y_out, w.vy);
          if (result.coincident !== w.coin)
            report_mismatch("coincident", result.coincident, w.coin);
        end
      end
      @(negedge clk);
    end
  end

  // Extremes of every field, held particles, a particle on the source and
  // positions that drive both the offset and the sums into saturation.
  task automatic test_directed();
    send_particle(10'd0, 32'sd0, 32'sd0, 24'd0, 1'b0);
    send_particle(10'd1, 32'sd65536, 32'sd0, 24'd4096, 1'b0);
    send_particle(10'd1, 32'sd65536, 32'sd0, 24'hFFFFFF, 1'b0);
    send_particle(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0);
    send_particle(10'd1023, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 1'b0);
    send_particle(10'd2, 32'sd1, 32'sd0, 24'hFFFFFF, 1'b0);
    send_particle(10'd2, -32'sd1, -32'sd1, 24'hFFFFFF, 1'b0);
    send_particle(10'd3, 32'sd100, 32'sd200, 24'd256, 1'b1);
    send_particle(10'd2, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 1'b1);
    send_particle(10'd512, 32'h0001_0000, -32'sh0002_0000, 24'h800000, 1'b0);
    wait_drained();
    write_reg(pgps_pkg::REG_SOURCE_X, 32'h8000_0000);
    write_reg(pgps_pkg::REG_SOURCE_Y, 32'h7FFF_FFFF);
    write_reg(pgps_pkg::REG_GRAVITY, 32'h7FFF_FFFF);
    send_particle(10'd4, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 1'b0);
    send_particle(10'd4, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0);
    send_particle(10'd5, 32'sd0, 32'sd0, 24'h123456, 1'b0);
    wait_drained();
    write_reg(pgps_pkg::REG_GRAVITY, 32'h8000_0000);
    write_reg(pgps_pkg::REG_SOURCE_X, 32'sd0);
    write_reg(pgps_pkg::REG_SOURCE_Y, 32'sd0);
    send_particle(10'd6, 32'sd3, 32'sd4, 24'hFFFFFF, 1'b0);
    send_particle(10'd6, 32'sd0, 32'sd0, 24'hFFFFFF, 1'b0);
    send_particle(10'd7, 32'h4000_0000, -32'sd5, 24'hFFFFFF, 1'b0);
    wait_drained();
  endtask

  // Random particles anywhere, on or near the source under a few random settings;
  // a small set of indexes, used for most particles, keeps velocities accumulating.
  task automatic test_random(int count);
    logic signed [31:0] px, py;
    logic [9:0] idx;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        wait_drained();
        write_reg(pgps_pkg::REG_SOURCE_X,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
        write_reg(pgps_pkg::REG_SOURCE_Y,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
        write_reg(pgps_pkg::REG_GRAVITY,
                  $urandom_range(0, 2) == 0 ? $urandom : -$urandom_range(0, 1 << 16));
      end
      idx = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: begin px = $urandom; py = $urandom; end
        1: begin px = src_x[31:0]; py = src_y[31:0]; end
        default: begin
          px = src_x[31:0] + $signed(32'($urandom_range(0, 1 << 22)) - 32'sd2097152);
          py = src_y[31:0] + $signed(32'($urandom_range(0, 1 << 22)) - 32'sd2097152);
        end
      endcase
      send_particle(idx, px, py, 24'($urandom), $urandom_range(0, 7) == 0);
      // Pressure: hold off until the block has fully drained once.
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    src_x = 0;
    src_y = 0;
    strength = -2294;
    for (int i = 0; i < NPART; i++) begin
      vel_x_mem[i] = 1966;
      vel_y_mem[i] = 0;
    end
    particle.valid = 1'b0;
    particle.particle_index = '0;
    particle.pos_x = '0;
    particle.pos_y = '0;
    particle.elapsed_ms = '0;
    particle.held = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1100);
    idle_allowed = 1'b0;
    test_random(200);
    wait_drained();
    repeat (500) @(negedge clk);
    $display("Covered %0d results, %0d held and %0d coincident particles,", results_seen,
             held_seen, coincident_seen);
    $display("over extreme and random source and strength settings.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Worst case is roughly 1330 particles plus stalls.
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/pgps_pkg.sv
sv/pgps_if.sv
sv/point_gravity_particle_step.sv
tb/tb_point_gravity_particle_step.sv
